FILE: sv/hbk_pkg.sv
package hbk_pkg;

  // Key slots carried by a boot report; the block may watch fewer of them
  localparam int MaxSlots    = 6;
  localparam int DefKeySlots = 6;

  localparam logic [6:0] MinReport   = 7'd8;
  localparam logic [7:0] CodeLctrl   = 8'h1D;
  localparam logic [7:0] CodeLshift  = 8'h2A;

  // Modifier byte bit positions
  localparam int ModLctrlBit  = 0;
  localparam int ModLshiftBit = 1;
  localparam int ModRshiftBit = 5;

  typedef struct packed {
    logic [6:0] report_length;
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } report_t;

  typedef struct packed {
    logic [7:0] event_code;
    logic       key_down;
    logic [6:0] ascii_char;
    logic       last_event;
  } key_evt_t;

  // Modifier state of the report being drained
  typedef struct packed {
    logic ctrl_down;
    logic shift_down;
    logic shifted;
  } mod_flags_t;

  // Usage code to ASCII, plain or shifted
  function automatic logic [6:0] key_char(input logic [7:0] code, input logic shifted);
    logic [6:0] lo;
    logic [6:0] hi;
    lo = 7'h00;
    hi = 7'h00;
    case (code) inside
      [8'h04:8'h1D]: begin
        lo = code[6:0] + 7'd93;   // 'a' - 4
        hi = code[6:0] + 7'd61;   // 'A' - 4
      end
      8'h1E: begin lo = 7'h31; hi = 7'h21; end
      8'h1F: begin lo = 7'h32; hi = 7'h40; end
      8'h20: begin lo = 7'h33; hi = 7'h23; end
      8'h21: begin lo = 7'h34; hi = 7'h24; end
      8'h22: begin lo = 7'h35; hi = 7'h25; end
      8'h23: begin lo = 7'h36; hi = 7'h5E; end
      8'h24: begin lo = 7'h37; hi = 7'h26; end
      8'h25: begin lo = 7'h38; hi = 7'h2A; end
      8'h26: begin lo = 7'h39; hi = 7'h28; end
      8'h27: begin lo = 7'h30; hi = 7'h29; end
      8'h28: begin lo = 7'h0A; hi = 7'h0A; end
      8'h29: begin lo = 7'h1B; hi = 7'h1B; end
      8'h2A: begin lo = 7'h08; hi = 7'h08; end
      8'h2B: begin lo = 7'h09; hi = 7'h09; end
      8'h2C: begin lo = 7'h20; hi = 7'h20; end
      8'h2D: begin lo = 7'h2D; hi = 7'h5F; end
      8'h2E: begin lo = 7'h3D; hi = 7'h2B; end
      8'h2F: begin lo = 7'h5B; hi = 7'h7B; end
      8'h30: begin lo = 7'h5D; hi = 7'h7D; end
      8'h31: begin lo = 7'h5C; hi = 7'h7C; end
      8'h33: begin lo = 7'h3B; hi = 7'h3A; end
      8'h34: begin lo = 7'h27; hi = 7'h22; end
      8'h35: begin lo = 7'h60; hi = 7'h7E; end
      8'h36: begin lo = 7'h2C; hi = 7'h3C; end
      8'h37: begin lo = 7'h2E; hi = 7'h3E; end
      8'h38: begin lo = 7'h2F; hi = 7'h3F; end
      default: begin lo = 7'h00; hi = 7'h00; end
    endcase
    return shifted ? hi : lo;
  endfunction

endpackage

FILE: sv/hbk_event_sel.sv
module hbk_event_sel
  import hbk_pkg::*;
#(
  parameter int KEY_SLOTS = DefKeySlots
) (
  input  logic [2*KEY_SLOTS+1:0] pending,
  input  mod_flags_t             mods,
  input  logic [7:0]             cur_keys [KEY_SLOTS],
  input  logic [7:0]             old_keys [KEY_SLOTS],
  output logic [2*KEY_SLOTS+1:0] pick,
  output logic [2*KEY_SLOTS+1:0] remaining,
  output key_evt_t               evt_item
);

  localparam int NumEvt = 2*KEY_SLOTS + 2;

  // Lowest pending bit wins: ctrl, shift, presses by slot, releases by slot
  assign pick      = pending & (~pending + NumEvt'(1));
  assign remaining = pending & ~pick;

  always_comb begin
    evt_item            = '0;
    evt_item.last_event = (remaining == '0);
    if (pick[0]) begin
      evt_item.event_code = CodeLctrl;
      evt_item.key_down   = mods.ctrl_down;
    end
    if (pick[1]) begin
      evt_item.event_code = CodeLshift;
      evt_item.key_down   = mods.shift_down;
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (pick[2+i]) begin
        evt_item.event_code = cur_keys[i];
        evt_item.key_down   = 1'b1;
        evt_item.ascii_char = key_char(cur_keys[i], mods.shifted);
      end
      if (pick[2+KEY_SLOTS+i]) begin
        evt_item.event_code = old_keys[i];
        evt_item.key_down   = 1'b0;
      end
    end
  end

endmodule

FILE: sv/hid_boot_keyboard_event_extractor_top.sv
// An accepted report loads the pending mask; each picked item is registered onto evt.
// Throughput: one event item per cycle unless evt_ready stalls the output; a report
// with no events leaves report_ready high for the next report.
// The next report is taken in the cycle the last event of the current one is emitted.
// Reset (rst, synchronous): previous modifiers and keys cleared, no events pending.
module hid_boot_keyboard_event_extractor_top
  import hbk_pkg::*;
#(
  parameter int KEY_SLOTS = DefKeySlots
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     report_valid,
  output logic     report_ready,
  input  report_t  report,
  output logic     evt_valid,
  input  logic     evt_ready,
  output key_evt_t evt
);

  localparam int NumEvt = 2*KEY_SLOTS + 2;

  logic [7:0]        prev_mods;
  logic [7:0]        last_keys [KEY_SLOTS];
  logic [7:0]        old_keys  [KEY_SLOTS];
  mod_flags_t        mods;
  logic [NumEvt-1:0] pending;

  logic [7:0]        in_keys   [MaxSlots];
  logic [NumEvt-1:0] new_mask;
  logic [NumEvt-1:0] pick;
  logic [NumEvt-1:0] remaining;
  logic [NumEvt-1:0] pending_after;
  key_evt_t          evt_item;
  logic              emit;
  logic              accept;
  logic              full_report;

  assign in_keys[0] = report.key_slot_0;
  assign in_keys[1] = report.key_slot_1;
  assign in_keys[2] = report.key_slot_2;
  assign in_keys[3] = report.key_slot_3;
  assign in_keys[4] = report.key_slot_4;
  assign in_keys[5] = report.key_slot_5;

  assign full_report = (report.report_length >= MinReport);

  // Diff of the incoming report against the stored one
  always_comb begin
    logic hit;
    logic [7:0] changed;
    changed     = report.modifier_bits ^ prev_mods;
    new_mask    = '0;
    new_mask[0] = changed[ModLctrlBit];
    new_mask[1] = changed[ModLshiftBit];
    for (int i = 0; i < KEY_SLOTS; i++) begin
      hit = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        hit = hit | (last_keys[j] == in_keys[i]);
      end
      new_mask[2+i] = (in_keys[i] != 8'h00) && !hit;
      hit = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        hit = hit | (in_keys[j] == last_keys[i]);
      end
      new_mask[2+KEY_SLOTS+i] = (last_keys[i] != 8'h00) && !hit;
    end
  end

  hbk_event_sel #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_sel (
    .pending   (pending),
    .mods      (mods),
    .cur_keys  (last_keys),
    .old_keys  (old_keys),
    .pick      (pick),
    .remaining (remaining),
    .evt_item  (evt_item)
  );

  assign emit          = (pending != '0) && (!evt_valid || evt_ready);
  assign pending_after = emit ? remaining : pending;
  assign report_ready  = (pending_after == '0);
  assign accept        = report_valid && report_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_mods <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        last_keys[i] <= '0;
      end
      pending   <= '0;
      evt_valid <= 1'b0;
    end else begin
      if (accept && full_report) begin
        pending   <= new_mask;
        prev_mods <= report.modifier_bits;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          last_keys[i] <= in_keys[i];
        end
      end else begin
        pending <= pending_after;
      end
      if (emit) begin
        evt_valid <= 1'b1;
      end else if (evt_ready) begin
        evt_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept && full_report) begin
      old_keys        <= last_keys;
      mods.ctrl_down  <= report.modifier_bits[ModLctrlBit];
      mods.shift_down <= report.modifier_bits[ModLshiftBit];
      mods.shifted    <= report.modifier_bits[ModLshiftBit] |
                         report.modifier_bits[ModRshiftBit];
    end
    if (emit) begin
      evt <= evt_item;
    end
  end

  // The event that drains a report's mask must carry the last mark
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    emit |-> (evt_item.last_event == (remaining == '0)))
    else $error("last_event does not match the drained mask");

  a_pick_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(pick) && ((pending == '0) || $onehot(pick)))
    else $error("event pick is not one-hot");

  a_short_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (accept && !full_report) |=> ($stable(prev_mods) && (pending == '0)))
    else $error("short report changed state");

  a_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && full_report) |=> (pending == $past(new_mask)))
    else $error("event mask not loaded on accept");

endmodule

FILE: dv/tb_hid_boot_keyboard_event_extractor_top.sv
`timescale 1ns / 100ps

module tb_hid_boot_keyboard_event_extractor_top;
  import hbk_pkg::*;

  localparam int Slots         = DefKeySlots;
  localparam int IdlePct       = 13;
  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 20;

  // Characters for usage codes 0x1E..0x38 (digits, control keys, space and punctuation)
  localparam logic [0:26][6:0] PunctPlain = '{
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
    7'h0A, 7'h1B, 7'h08, 7'h09, 7'h20, 7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C,
    7'h00, 7'h3B, 7'h27, 7'h60, 7'h2C, 7'h2E, 7'h2F
  };
  localparam logic [0:26][6:0] PunctShifted = '{
    7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
    7'h0A, 7'h1B, 7'h08, 7'h09, 7'h20, 7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C,
    7'h00, 7'h3A, 7'h22, 7'h7E, 7'h3C, 7'h3E, 7'h3F
  };

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     report_valid = 1'b0;
  logic     report_ready;
  report_t  report = '0;
  logic     evt_valid;
  logic     evt_ready = 1'b0;
  key_evt_t evt;

  hid_boot_keyboard_event_extractor_top #(
    .KEY_SLOTS(Slots)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report),
    .evt_valid    (evt_valid),
    .evt_ready    (evt_ready),
    .evt          (evt)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Keyboard state as seen by the predictor
  logic [7:0]                held_mods = '0;
  logic [MaxSlots-1:0][7:0]  held_keys = '0;
  key_evt_t                  expected_evts [$];

  // Last well-formed report handed to the block, used to shape random traffic
  logic [7:0]                last_sent_mods = '0;
  logic [MaxSlots-1:0][7:0]  last_sent_keys = '0;

  bit idle_en = 1'b1;
  int fails = 0;
  int quiet_cycles = 0;

  function automatic logic [6:0] usage_to_ascii(logic [7:0] code, bit shifted);
    if (code >= 8'h04 && code <= 8'h1D)
      return (shifted ? 7'h41 : 7'h61) + 7'(code - 8'h04);
    if (code >= 8'h1E && code <= 8'h38)
      return shifted ? PunctShifted[code - 8'h1E] : PunctPlain[code - 8'h1E];
    return 7'h00;
  endfunction

  function automatic bit slot_match(logic [MaxSlots-1:0][7:0] keys, logic [7:0] code);
    for (int i = 0; i < Slots; i++)
      if (keys[i] == code) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void predict_report(report_t r);
    logic [MaxSlots-1:0][7:0] cur;
    logic [7:0] mods;
    logic [7:0] diff;
    bit         shifted;
    key_evt_t   batch [14];
    int         n;
    n = 0;
    if (r.report_length < MinReport) return;
    cur = {r.key_slot_5, r.key_slot_4, r.key_slot_3, r.key_slot_2, r.key_slot_1, r.key_slot_0};
    mods = r.modifier_bits;
    diff = mods ^ held_mods;
    if (diff[ModLctrlBit]) begin
      batch[n] = '{CodeLctrl, mods[ModLctrlBit], 7'h00, 1'b0};
      n++;
    end
    if (diff[ModLshiftBit]) begin
      batch[n] = '{CodeLshift, mods[ModLshiftBit], 7'h00, 1'b0};
      n++;
    end
    shifted = mods[ModLshiftBit] | mods[ModRshiftBit];
    // a press only counts if the code sat in none of the previous slots
    for (int i = 0; i < Slots; i++) begin
      if (cur[i] != 8'h00 && !slot_match(held_keys, cur[i])) begin
        batch[n] = '{cur[i], 1'b1, usage_to_ascii(cur[i], shifted), 1'b0};
        n++;
      end
    end
    for (int i = 0; i < Slots; i++) begin
      if (held_keys[i] != 8'h00 && !slot_match(cur, held_keys[i])) begin
        batch[n] = '{held_keys[i], 1'b0, 7'h00, 1'b0};
        n++;
      end
    end
    if (n > 0) batch[n-1].last_event = 1'b1;
    for (int i = 0; i < n; i++) expected_evts.push_back(batch[i]);
    held_mods = mods;
    held_keys = '0;
    for (int i = 0; i < Slots; i++) held_keys[i] = cur[i];
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  // Predict on report acceptance, compare on event acceptance, one process
  always @(posedge clk) begin : monitor
    key_evt_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (report_valid && report_ready) predict_report(report);
      if (evt_valid && evt_ready) begin
        if (expected_evts.size() == 0) begin
          $error("unexpected event item, event_code %0h", evt.event_code);
          fails++;
        end else begin
          want = expected_evts.pop_front();
          check_field("event_code", want.event_code, evt.event_code);
          check_field("key_down", 8'(want.key_down), 8'(evt.key_down));
          check_field("ascii_char", 8'(want.ascii_char), 8'(evt.ascii_char));
          check_field("last_event", 8'(want.last_event), 8'(evt.last_event));
        end
      end
      if ((report_valid && report_ready) || (evt_valid && evt_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk)
    evt_ready <= !(idle_en && $urandom_range(99) < IdlePct);

  initial begin
    while (quiet_cycles < WatchdogLimit) @(posedge clk);
    $display("tb_hid_boot_keyboard_event_extractor_top: FAIL");
    $finish;
  end

  task automatic send_report(input report_t r);
    while (idle_en && $urandom_range(99) < IdlePct) begin
      report_valid <= 1'b0;
      @(posedge clk);
    end
    report_valid <= 1'b1;
    report <= r;
    @(posedge clk);
    while (!report_ready) @(posedge clk);
    if (r.report_length >= MinReport) begin
      last_sent_mods = r.modifier_bits;
      last_sent_keys = {r.key_slot_5, r.key_slot_4, r.key_slot_3,
                        r.key_slot_2, r.key_slot_1, r.key_slot_0};
    end
  endtask

  function automatic report_t mk_report(int len, logic [7:0] mods,
                                        logic [7:0] k0, logic [7:0] k1, logic [7:0] k2,
                                        logic [7:0] k3, logic [7:0] k4, logic [7:0] k5);
    return '{7'(len), mods, k0, k1, k2, k3, k4, k5};
  endfunction

  // Mostly evolves the last report so keys are held, moved, dropped and added
  function automatic report_t random_report();
    report_t r;
    logic [MaxSlots-1:0][7:0] k;
    logic [7:0] m;
    int roll;
    if ($urandom_range(99) < 8) begin
      r = report_t'(63'({$urandom, $urandom}));
      r.report_length = 7'($urandom_range(64));
      return r;
    end
    m = last_sent_mods;
    case ($urandom_range(3))
      0: m = 8'($urandom_range(255));
      1: m[ModLctrlBit] = ~m[ModLctrlBit];
      2: m[ModLshiftBit] = ~m[ModLshiftBit];
      default: m[ModRshiftBit] = ~m[ModRshiftBit];
    endcase
    for (int i = 0; i < MaxSlots; i++) begin
      roll = $urandom_range(99);
      if (roll < 45) k[i] = last_sent_keys[i];
      else if (roll < 55) k[i] = last_sent_keys[$urandom_range(Slots - 1)];
      else if (roll < 75) k[i] = 8'h00;
      else if (roll < 95) k[i] = 8'($urandom_range(58, 4));
      else k[i] = 8'($urandom_range(255));
    end
    r = mk_report(0, m, k[0], k[1], k[2], k[3], k[4], k[5]);
    r.report_length = ($urandom_range(9) == 0) ? 7'($urandom_range(7))
                                                : 7'($urandom_range(64, 8));
    return r;
  endfunction

  task automatic test_short_report();
    send_report(mk_report(0, 8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    send_report(mk_report(7, 8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    send_report(mk_report(8, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // identical report, nothing to say
    send_report(mk_report(64, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_modifier_events();
    send_report(mk_report(8, 8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk_report(8, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // right shift raises no event of its own, only the ctrl and left shift releases
    send_report(mk_report(8, 8'h20, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk_report(8, 8'hFF, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk_report(8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_key_mapping();
    // no-character codes, escape, last mapped code
    send_report(mk_report(8, 8'h00, 8'h01, 8'h02, 8'h03, 8'h29, 8'h32, 8'h38));
    // right shift selects the upper table; 0x39 is past the table
    send_report(mk_report(8, 8'h20, 8'h1E, 8'h1F, 8'h27, 8'h2D, 8'h35, 8'h39));
    send_report(mk_report(8, 8'h02, 8'h04, 8'h1D, 8'h28, 8'h2A, 8'h2C, 8'hFF));
    send_report(mk_report(8, 8'h00, 8'h04, 8'h1D, 8'h28, 8'h2A, 8'h2C, 8'hFF));
  endtask

  task automatic test_repeated_codes();
    send_report(mk_report(8, 8'h00, 8'h33, 8'h33, 8'h00, 8'h00, 8'h34, 8'h34));
    send_report(mk_report(8, 8'h00, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // key moved to another slot: still held
    send_report(mk_report(8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h34));
  endtask

  task automatic test_full_turnover();
    send_report(mk_report(8, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    // both modifiers, six presses, six releases
    send_report(mk_report(8, 8'h03, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F));
    send_report(mk_report(8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_report(random_report());
  endtask

  task automatic test_back_to_back(input int count);
    idle_en = 1'b0;
    repeat (count) send_report(random_report());
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_short_report();
    test_modifier_events();
    test_key_mapping();
    test_repeated_codes();
    test_full_turnover();
    test_random_traffic(200);
    test_back_to_back(60);
    test_random_traffic(100);
    report_valid <= 1'b0;
    while (expected_evts.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fails == 0 && expected_evts.size() == 0)
      $display("tb_hid_boot_keyboard_event_extractor_top: PASS");
    else
      $display("tb_hid_boot_keyboard_event_extractor_top: FAIL");
    $finish;
  end

endmodule
